@@ design/htr_pkg.sv @@
`default_nettype none

package htr_pkg;

  // input limits
  localparam logic [8:0] HueMax  = 9'd360;
  localparam logic [7:0] ChanMax = 8'd255;

  // reciprocal constants for the constant dividers
  localparam logic [9:0]  Div3By5Mul = 10'd855;   // x*5/3 ~ (x*855) >> 9
  localparam logic [8:0]  Div255Mul  = 9'd257;    // x/255 ~ (x*257) >> 16, low by at most 1
  localparam logic [15:0] Div100Mul  = 16'd41943; // x/100 ~ (x*41943) >> 22, low by at most 1
  localparam logic [7:0]  Div255     = 8'd255;
  localparam logic [6:0]  Div100     = 7'd100;

  typedef enum logic [2:0] {
    Sec0 = 3'd0,
    Sec1 = 3'd1,
    Sec2 = 3'd2,
    Sec3 = 3'd3,
    Sec4 = 3'd4,
    Sec5 = 3'd5,
    Sec6 = 3'd6
  } htr_sector_e;

  // front end: clamped inputs and hue split
  typedef struct packed {
    logic [15:0] idx;
    htr_sector_e sector;
    logic [5:0]  rem;
    logic [7:0]  sat;
    logic [7:0]  val;
  } htr_s1_t;

  typedef struct packed {
    logic [15:0] idx;
    htr_sector_e sector;
    logic        grey;
    logic [7:0]  val;
    logic [6:0]  frac;
    logic [15:0] prod;
  } htr_s2_t;

  typedef struct packed {
    logic [15:0] idx;
    htr_sector_e sector;
    logic        grey;
    logic [7:0]  val;
    logic [15:0] prod;
    logic [7:0]  vs_est;
    logic [22:0] vfs_prod;
  } htr_s3_t;

  typedef struct packed {
    logic [15:0] idx;
    htr_sector_e sector;
    logic        grey;
    logic [7:0]  val;
    logic [7:0]  vs;
    logic [22:0] vfs_prod;
    logic [14:0] vfs_est;
  } htr_s4_t;

  typedef struct packed {
    logic [15:0] idx;
    htr_sector_e sector;
    logic        grey;
    logic [7:0]  val;
    logic [7:0]  vs;
    logic [14:0] vfs;
    logic [14:0] num_q;
  } htr_s5_t;

  typedef struct packed {
    logic [15:0] idx;
    htr_sector_e sector;
    logic        grey;
    logic [7:0]  val;
    logic [7:0]  vs;
    logic [14:0] vfs;
    logic [14:0] num_q;
    logic [7:0]  q_est;
    logic [7:0]  d_est;
  } htr_s6_t;

  typedef struct packed {
    logic [15:0] idx;
    htr_sector_e sector;
    logic        grey;
    logic [7:0]  val;
    logic [7:0]  p;
    logic [7:0]  q;
    logic [7:0]  t;
  } htr_s7_t;

endpackage

`default_nettype wire

@@ design/hsv_to_rgb_integer.sv @@
// channel   | ports                                                   | dir | handshake
// ----------+---------------------------------------------------------+-----+------------------
// request   | led_index_i, hue_i, saturation_i, brightness_i         | in  | start, busy
// pixel     | out_index_o, red_o, green_o, blue_o                    | out | done_o strobe
//
// every beat runs the whole pipeline from start to done_o; one beat can enter each cycle
// the latency is set by the chain of constant dividers (by 255, then by 100),
// each split into a reciprocal multiply stage and a correction stage
// busy is always low: the pipeline never stalls and the receiver cannot stall it
// reset (rst_ni low) clears only the stage valid bits; data registers are not reset
`default_nettype none

module hsv_to_rgb_integer
  import htr_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [15:0] led_index_i,
  input  wire logic [15:0] hue_i,
  input  wire logic [15:0] saturation_i,
  input  wire logic [15:0] brightness_i,
  output logic             done_o,
  output logic [15:0]      out_index_o,
  output logic [7:0]       red_o,
  output logic [7:0]       green_o,
  output logic [7:0]       blue_o
);

  localparam int Latency = 8;

  logic    front_valid;
  htr_s2_t front_data;
  logic    scale_valid;
  htr_s6_t scale_data;
  logic    accept;

  // free running pipeline, so a request is taken whenever start is high
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // stages 1-2: clamp inputs, split hue into sector and hundredths, form v*s
  htr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (accept),
    .led_index_i  (led_index_i),
    .hue_i        (hue_i),
    .saturation_i (saturation_i),
    .brightness_i (brightness_i),
    .valid_o      (front_valid),
    .data_o       (front_data)
  );

  // stages 3-6: vs = v*s/255, vfs = v*s*f/255, then estimates of the /100 terms
  htr_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (front_valid),
    .data_i  (front_data),
    .valid_o (scale_valid),
    .data_o  (scale_data)
  );

  // stages 7-8: p, q, t with t clamp, then routing by sector into output regs
  htr_route u_route (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (scale_valid),
    .data_i  (scale_data),
    .valid_o (done_o),
    .index_o (out_index_o),
    .red_o   (red_o),
    .green_o (green_o),
    .blue_o  (blue_o)
  );

  // a result beat only comes from a request accepted a full latency earlier
  a_done_has_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, Latency))
    else $error("result without a matching request");

  // index travels unchanged with its beat
  a_index_passes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (out_index_o == $past(led_index_i, Latency)))
    else $error("index does not match its request");

  // zero saturation yields grey
  a_grey: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && ($past(saturation_i, Latency) == 16'd0))
      |-> ((red_o == green_o) && (green_o == blue_o)))
    else $error("zero saturation did not give grey");

endmodule

`default_nettype wire

@@ design/htr_front.sv @@
`default_nettype none

module htr_front
  import htr_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        valid_i,
  input  wire logic [15:0] led_index_i,
  input  wire logic [15:0] hue_i,
  input  wire logic [15:0] saturation_i,
  input  wire logic [15:0] brightness_i,
  output logic             valid_o,
  output htr_s2_t          data_o
);

  logic        hue_big;
  logic [8:0]  hue_c;
  logic [8:0]  base;
  htr_s1_t     s1_d, s1_q;
  htr_s2_t     s2_d, s2_q;
  logic        v1_q, v2_q;
  logic [15:0] frac_mul;

  // clamp, then sector by compare chain
  always_comb begin
    hue_big = (hue_i > 16'(HueMax));
    hue_c   = hue_big ? HueMax : hue_i[8:0];
    if (hue_c >= 9'd360) begin
      s1_d.sector = Sec6;
      base        = 9'd360;
    end else if (hue_c >= 9'd300) begin
      s1_d.sector = Sec5;
      base        = 9'd300;
    end else if (hue_c >= 9'd240) begin
      s1_d.sector = Sec4;
      base        = 9'd240;
    end else if (hue_c >= 9'd180) begin
      s1_d.sector = Sec3;
      base        = 9'd180;
    end else if (hue_c >= 9'd120) begin
      s1_d.sector = Sec2;
      base        = 9'd120;
    end else if (hue_c >= 9'd60) begin
      s1_d.sector = Sec1;
      base        = 9'd60;
    end else begin
      s1_d.sector = Sec0;
      base        = 9'd0;
    end
    s1_d.idx = led_index_i;
    s1_d.rem = 6'(hue_c - base);
    s1_d.sat = (saturation_i > 16'(ChanMax)) ? ChanMax : saturation_i[7:0];
    s1_d.val = (brightness_i > 16'(ChanMax)) ? ChanMax : brightness_i[7:0];
  end

  // fraction in hundredths and v*s
  always_comb begin
    frac_mul    = 16'(s1_q.rem) * 16'(Div3By5Mul);
    s2_d.idx    = s1_q.idx;
    s2_d.sector = s1_q.sector;
    s2_d.grey   = (s1_q.sat == 8'd0);
    s2_d.val    = s1_q.val;
    s2_d.frac   = frac_mul[15:9];
    s2_d.prod   = 16'(s1_q.sat) * 16'(s1_q.val);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q <= s1_d;
    s2_q <= s2_d;
  end

  assign valid_o = v2_q;
  assign data_o  = s2_q;

endmodule

`default_nettype wire

@@ design/htr_scale.sv @@
`default_nettype none

module htr_scale
  import htr_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    valid_i,
  input  wire htr_s2_t data_i,
  output logic         valid_o,
  output htr_s6_t      data_o
);

  htr_s3_t     s3_d, s3_q;
  htr_s4_t     s4_d, s4_q;
  htr_s5_t     s5_d, s5_q;
  htr_s6_t     s6_d, s6_q;
  logic        v3_q, v4_q, v5_q, v6_q;
  logic [23:0] vs_mul;
  logic [16:0] vs_rem;
  logic [31:0] vfs_mul;
  logic [23:0] vfs_rem;
  logic [14:0] vfs_fix;
  logic [30:0] q_mul;
  logic [30:0] d_mul;

  // v*s/255 estimate and v*s*f
  always_comb begin
    vs_mul        = 24'(data_i.prod) * 24'(Div255Mul);
    s3_d.idx      = data_i.idx;
    s3_d.sector   = data_i.sector;
    s3_d.grey     = data_i.grey;
    s3_d.val      = data_i.val;
    s3_d.prod     = data_i.prod;
    s3_d.vs_est   = vs_mul[23:16];
    s3_d.vfs_prod = 23'(data_i.prod) * 23'(data_i.frac);
  end

  // fix vs, estimate vfs
  always_comb begin
    vs_rem        = 17'(s3_q.prod) - 17'(s3_q.vs_est) * 17'(Div255);
    vfs_mul       = 32'(s3_q.vfs_prod) * 32'(Div255Mul);
    s4_d.idx      = s3_q.idx;
    s4_d.sector   = s3_q.sector;
    s4_d.grey     = s3_q.grey;
    s4_d.val      = s3_q.val;
    s4_d.vs       = (vs_rem >= 17'(Div255)) ? s3_q.vs_est + 8'd1 : s3_q.vs_est;
    s4_d.vfs_prod = s3_q.vfs_prod;
    s4_d.vfs_est  = vfs_mul[30:16];
  end

  // fix vfs, form 100v - vfs
  always_comb begin
    vfs_rem     = 24'(s4_q.vfs_prod) - 24'(s4_q.vfs_est) * 24'(Div255);
    vfs_fix     = (vfs_rem >= 24'(Div255)) ? s4_q.vfs_est + 15'd1 : s4_q.vfs_est;
    s5_d.idx    = s4_q.idx;
    s5_d.sector = s4_q.sector;
    s5_d.grey   = s4_q.grey;
    s5_d.val    = s4_q.val;
    s5_d.vs     = s4_q.vs;
    s5_d.vfs    = vfs_fix;
    s5_d.num_q  = 15'(s4_q.val) * 15'(Div100) - vfs_fix;
  end

  // both divides by 100, estimates
  always_comb begin
    q_mul       = 31'(s5_q.num_q) * 31'(Div100Mul);
    d_mul       = 31'(s5_q.vfs) * 31'(Div100Mul);
    s6_d.idx    = s5_q.idx;
    s6_d.sector = s5_q.sector;
    s6_d.grey   = s5_q.grey;
    s6_d.val    = s5_q.val;
    s6_d.vs     = s5_q.vs;
    s6_d.vfs    = s5_q.vfs;
    s6_d.num_q  = s5_q.num_q;
    s6_d.q_est  = q_mul[29:22];
    s6_d.d_est  = d_mul[29:22];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      v3_q <= valid_i;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_q <= s3_d;
    s4_q <= s4_d;
    s5_q <= s5_d;
    s6_q <= s6_d;
  end

  assign valid_o = v6_q;
  assign data_o  = s6_q;

endmodule

`default_nettype wire

@@ design/htr_route.sv @@
`default_nettype none

module htr_route
  import htr_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    valid_i,
  input  wire htr_s6_t data_i,
  output logic         valid_o,
  output logic [15:0]  index_o,
  output logic [7:0]   red_o,
  output logic [7:0]   green_o,
  output logic [7:0]   blue_o
);

  htr_s7_t     s7_d, s7_q;
  logic        v7_q, v8_q;
  logic [14:0] q_rem;
  logic [14:0] d_rem;
  logic [7:0]  d_fix;
  logic [7:0]  p_lvl;
  logic [8:0]  t_sum;
  logic [15:0] idx_d, idx_q;
  logic [7:0]  red_d, red_q;
  logic [7:0]  green_d, green_q;
  logic [7:0]  blue_d, blue_q;

  // fix the divides, form p, q, t
  always_comb begin
    q_rem       = data_i.num_q - 15'(data_i.q_est) * 15'(Div100);
    d_rem       = data_i.vfs - 15'(data_i.d_est) * 15'(Div100);
    d_fix       = (d_rem >= 15'(Div100)) ? data_i.d_est + 8'd1 : data_i.d_est;
    p_lvl       = data_i.val - data_i.vs;
    t_sum       = 9'(p_lvl) + 9'(d_fix);
    s7_d.idx    = data_i.idx;
    s7_d.sector = data_i.sector;
    s7_d.grey   = data_i.grey;
    s7_d.val    = data_i.val;
    s7_d.p      = p_lvl;
    s7_d.q      = (q_rem >= 15'(Div100)) ? data_i.q_est + 8'd1 : data_i.q_est;
    s7_d.t      = (t_sum > 9'(ChanMax)) ? ChanMax : t_sum[7:0];
  end

  // sector routing
  always_comb begin
    idx_d = s7_q.idx;
    if (s7_q.grey) begin
      red_d   = s7_q.val;
      green_d = s7_q.val;
      blue_d  = s7_q.val;
    end else begin
      unique case (s7_q.sector)
        Sec1: begin
          red_d = s7_q.q;   green_d = s7_q.val; blue_d = s7_q.p;
        end
        Sec2: begin
          red_d = s7_q.p;   green_d = s7_q.val; blue_d = s7_q.t;
        end
        Sec3: begin
          red_d = s7_q.p;   green_d = s7_q.q;   blue_d = s7_q.val;
        end
        Sec4: begin
          red_d = s7_q.t;   green_d = s7_q.p;   blue_d = s7_q.val;
        end
        Sec5: begin
          red_d = s7_q.val; green_d = s7_q.p;   blue_d = s7_q.q;
        end
        default: begin
          red_d = s7_q.val; green_d = s7_q.t;   blue_d = s7_q.p;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v7_q <= 1'b0;
      v8_q <= 1'b0;
    end else begin
      v7_q <= valid_i;
      v8_q <= v7_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s7_q    <= s7_d;
    idx_q   <= idx_d;
    red_q   <= red_d;
    green_q <= green_d;
    blue_q  <= blue_d;
  end

  assign valid_o = v8_q;
  assign index_o = idx_q;
  assign red_o   = red_q;
  assign green_o = green_q;
  assign blue_o  = blue_q;

endmodule

`default_nettype wire
